FILE: design/srap_pkg.sv
// Package for the sequential read-ahead prefetcher.
// Holds field widths, configuration codes and reset values, and the shared struct types.
// No dependencies; every other design file imports it.
`default_nettype none

package srap_pkg;

    // Field widths.
    localparam int POS_W    = 63;
    localparam int LEN_W    = 32;
    localparam int CFG_W    = 32;
    localparam int HANDLE_W = 4;

    // Handle table size and the index width that follows from it.
    localparam int NUM_HANDLES = 16;
    localparam int IDX_W       = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;

    // Configuration port.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH    = 2'd0,
        CFG_WINDOW        = 2'd1,
        CFG_REFILL_MARGIN = 2'd2
    } cfg_index_t;

    localparam logic [CFG_W-1:0] MIN_LENGTH_RST    = 32'd4096;
    localparam logic [CFG_W-1:0] WINDOW_RST        = 32'd1048576;
    localparam logic [CFG_W-1:0] REFILL_MARGIN_RST = 32'd262144;

    // Item kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // Largest byte position.
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic [CFG_W-1:0] min_length;
        logic [CFG_W-1:0] window;
        logic [CFG_W-1:0] refill_margin;
    } cfg_t;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        logic                handle_open;
        logic                driver_backed;
        logic [POS_W-1:0]    offset;
        logic [LEN_W-1:0]    length;
        logic [POS_W-1:0]    size_bytes;
    } req_t;

    typedef struct packed {
        logic             accepted;
        logic             sequential;
        logic             hint_issued;
        logic             via_driver;
        logic [POS_W-1:0] ahead_start;
        logic [POS_W-1:0] ahead_end;
    } rsp_t;

    // Per-handle stream state.
    typedef struct packed {
        logic [POS_W-1:0] last_end;
        logic             last_end_known;
        logic [POS_W-1:0] ahead_frontier;
    } entry_t;

    // Write command into the handle table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } upd_t;

endpackage

`default_nettype wire

FILE: design/srap_if.sv
// Request and result channel interfaces of the read-ahead prefetcher.
// Each carries valid, ready and the item fields. Depends on srap_pkg.
`default_nettype none

interface srap_req_if import srap_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic                handle_open;
    logic                driver_backed;
    logic [POS_W-1:0]    offset;
    logic [LEN_W-1:0]    length;
    logic [POS_W-1:0]    size_bytes;

    modport source (
        output valid, kind, handle, handle_open, driver_backed, offset, length, size_bytes,
        input  ready
    );

    modport sink (
        input  valid, kind, handle, handle_open, driver_backed, offset, length, size_bytes,
        output ready
    );
endinterface

interface srap_rsp_if import srap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             sequential;
    logic             hint_issued;
    logic             via_driver;
    logic [POS_W-1:0] ahead_start;
    logic [POS_W-1:0] ahead_end;

    modport source (
        output valid, accepted, sequential, hint_issued, via_driver, ahead_start, ahead_end,
        input  ready
    );

    modport sink (
        input  valid, accepted, sequential, hint_issued, via_driver, ahead_start, ahead_end,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/srap_entry_table.sv
// Per-handle stream state table of the read-ahead prefetcher.
// One combinational read port and one write port; reset clears every entry.
// Depends on srap_pkg.
`default_nettype none

module srap_entry_table import srap_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_entry,
    input  upd_t                  upd
);

    entry_t entry_reg [NUM_HANDLES];

    // The selected entry feeds the policy logic directly.
    assign rd_entry = entry_reg[rd_idx];

    // Entries are cleared by reset and rewritten one at a time afterwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_HANDLES; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (upd.en)
        begin
            entry_reg[upd.idx] <= upd.entry;
        end
    end

endmodule

`default_nettype wire

FILE: design/srap_policy.sv
// Read-ahead policy for one request: guards, end clamp, stream detection and hint range.
// Purely combinational; produces the result item and the new handle entry.
// Depends on srap_pkg.
`default_nettype none

module srap_policy import srap_pkg::*; (
    input  cfg_t   cfg,
    input  req_t   req,
    input  entry_t cur,
    output rsp_t   rsp,
    output logic   upd_en,
    output entry_t upd_entry
);

    logic             in_range;
    logic [POS_W:0]   end_sum;
    logic [POS_W-1:0] end_raw;
    logic [POS_W-1:0] end_c;
    logic             size_known;
    logic             read_ok;
    logic             seq;
    logic [POS_W:0]   lw_sum;
    logic [POS_W-1:0] lw;
    logic [POS_W:0]   win_sum;
    logic [POS_W-1:0] win_sat;
    logic [POS_W-1:0] win_c;
    logic [POS_W-1:0] hs;
    logic [POS_W-1:0] he;
    logic [POS_W-1:0] span;
    logic             nonempty;
    logic             issued;
    logic [POS_W-1:0] frontier_new;

    assign in_range   = 32'(req.handle) < 32'(NUM_HANDLES);
    assign size_known = req.size_bytes != '0;

    // Read end; the top bit of the sum flags a run past the largest position.
    assign end_sum = {1'b0, req.offset} + (POS_W+1)'(req.length);
    assign end_raw = end_sum[POS_W-1:0];
    assign end_c   = (size_known && end_raw > req.size_bytes) ? req.size_bytes : end_raw;

    // Guards on a read request.
    assign read_ok = in_range && (req.kind == KIND_READ) && req.handle_open
                     && (req.length >= cfg.min_length) && !end_sum[POS_W]
                     && (end_c > req.offset);

    // A read is sequential on a fresh stream or when it starts at the previous end.
    assign seq = !cur.last_end_known || (req.offset == cur.last_end);

    // Saturating sums past the read end.
    assign lw_sum  = {1'b0, end_c} + (POS_W+1)'(cfg.refill_margin);
    assign lw      = lw_sum[POS_W] ? POS_MAX : lw_sum[POS_W-1:0];
    assign win_sum = {1'b0, end_c} + (POS_W+1)'(cfg.window);
    assign win_sat = win_sum[POS_W] ? POS_MAX : win_sum[POS_W-1:0];
    assign win_c   = (size_known && win_sat > req.size_bytes) ? req.size_bytes : win_sat;

    // Hint range selection.
    always_comb
    begin
        hs = '0;
        he = '0;
        if (!seq)
        begin
            if (!req.driver_backed)
            begin
                hs = req.offset;
                he = end_c;
            end
        end
        else if (req.driver_backed)
        begin
            hs = end_c;
            he = win_c;
        end
        else if (cur.ahead_frontier <= lw)
        begin
            hs = (cur.ahead_frontier > req.offset) ? cur.ahead_frontier : req.offset;
            he = win_c;
        end
    end

    // A short hint still moves the frontier but is not issued.
    assign nonempty = he > hs;
    assign span     = he - hs;
    assign issued   = nonempty && (span >= POS_W'(cfg.min_length));

    always_comb
    begin
        if (nonempty)
        begin
            frontier_new = he;
        end
        else if (!seq)
        begin
            frontier_new = '0;
        end
        else
        begin
            frontier_new = cur.ahead_frontier;
        end
    end

    // Entry update: an accepted read records its end, a reset item clears the entry.
    assign upd_en = read_ok || (in_range && (req.kind == KIND_RESET));

    always_comb
    begin
        upd_entry = '0;
        if (read_ok)
        begin
            upd_entry.last_end       = end_c;
            upd_entry.last_end_known = 1'b1;
            upd_entry.ahead_frontier = frontier_new;
        end
    end

    // Result fields are zero unless the read was accepted.
    always_comb
    begin
        rsp             = '0;
        rsp.accepted    = read_ok;
        rsp.sequential  = read_ok && seq;
        rsp.hint_issued = read_ok && issued;
        rsp.via_driver  = read_ok && req.driver_backed;
        if (read_ok && issued)
        begin
            rsp.ahead_start = hs;
            rsp.ahead_end   = he;
        end
    end

endmodule

`default_nettype wire

FILE: design/sequential_read_ahead_prefetcher.sv
// Sequential read-ahead prefetcher, top level.
// A transferred request is held in the input register, passes the policy logic and
// is loaded into the result register, from which its result is offered.
// Throughput: one request per cycle while results are taken; the handle table is
// read and written in the same cycle, so a request on the same handle right behind
// sees the updated entry. Reset clears handle entries and valid flags, loads config.
// Depends on srap_pkg, srap_if, srap_entry_table and srap_policy.
`default_nettype none

module sequential_read_ahead_prefetcher import srap_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    srap_req_if.sink                  req,
    srap_rsp_if.source                rsp,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t   cfg_reg;
    req_t   req_reg;
    logic   req_valid_reg;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;

    logic   advance;
    logic   fire;
    logic   req_xfer;
    entry_t cur_entry;
    rsp_t   rsp_next;
    logic   upd_en;
    entry_t upd_entry;
    upd_t   upd;

    // Pipeline control: the input register moves on whenever the result register is free.
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length    <= MIN_LENGTH_RST;
            cfg_reg.window        <= WINDOW_RST;
            cfg_reg.refill_margin <= REFILL_MARGIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_LENGTH:    cfg_reg.min_length    <= cfg_wdata;
                CFG_WINDOW:        cfg_reg.window        <= cfg_wdata;
                CFG_REFILL_MARGIN: cfg_reg.refill_margin <= cfg_wdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_xfer)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_reg.kind          <= req.kind;
            req_reg.handle        <= req.handle;
            req_reg.handle_open   <= req.handle_open;
            req_reg.driver_backed <= req.driver_backed;
            req_reg.offset        <= req.offset;
            req_reg.length        <= req.length;
            req_reg.size_bytes    <= req.size_bytes;
        end
    end

    // Handle state table.
    assign upd.en    = fire && upd_en;
    assign upd.idx   = IDX_W'(req_reg.handle);
    assign upd.entry = upd_entry;

    srap_entry_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (IDX_W'(req_reg.handle)),
        .rd_entry (cur_entry),
        .upd      (upd)
    );

    // Policy logic between the input and result registers.
    srap_policy u_policy (
        .cfg       (cfg_reg),
        .req       (req_reg),
        .cur       (cur_entry),
        .rsp       (rsp_next),
        .upd_en    (upd_en),
        .upd_entry (upd_entry)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.accepted    = rsp_reg.accepted;
    assign rsp.sequential  = rsp_reg.sequential;
    assign rsp.hint_issued = rsp_reg.hint_issued;
    assign rsp.via_driver  = rsp_reg.via_driver;
    assign rsp.ahead_start = rsp_reg.ahead_start;
    assign rsp.ahead_end   = rsp_reg.ahead_end;

endmodule

`default_nettype wire
